### sv/pad_pkg.sv
// Shared constants, codes and types of the physical address decoder.
package pad_pkg;

    localparam int ROM_SIZE  = 4096;
    localparam int SRAM_SIZE = 8192;
    localparam int MAIN_SIZE = 65536;

    localparam int ACCESS_BYTES = 4;

    // Each RAM region is split into four byte banks, one per byte lane.
    localparam int SRAM_ROWS  = (SRAM_SIZE + ACCESS_BYTES - 1) / ACCESS_BYTES;
    localparam int MAIN_ROWS  = (MAIN_SIZE + ACCESS_BYTES - 1) / ACCESS_BYTES;
    localparam int SRAM_ROW_W = (SRAM_ROWS > 1) ? $clog2(SRAM_ROWS) : 1;
    localparam int MAIN_ROW_W = (MAIN_ROWS > 1) ? $clog2(MAIN_ROWS) : 1;
    localparam int ROW_W      = (SRAM_ROW_W > MAIN_ROW_W) ? SRAM_ROW_W : MAIN_ROW_W;

    // Last offset at which all four bytes still lie inside a region.
    localparam logic [31:0] ROM_LIM  = 32'(ROM_SIZE - ACCESS_BYTES);
    localparam logic [31:0] SRAM_LIM = 32'(SRAM_SIZE - ACCESS_BYTES);
    localparam logic [31:0] MAIN_LIM = 32'(MAIN_SIZE - ACCESS_BYTES);

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PW    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    localparam int PADDR_W = 4;

    localparam logic [1:0] REG_ROM_BASE  = 2'd0;
    localparam logic [1:0] REG_SRAM_BASE = 2'd1;
    localparam logic [1:0] REG_MAIN_BASE = 2'd2;

    localparam logic [31:0] ROM_BASE_RST  = 32'h2000_0000;
    localparam logic [31:0] SRAM_BASE_RST = 32'h0F00_0000;
    localparam logic [31:0] MAIN_BASE_RST = 32'h8000_0000;

    localparam logic [1:0] KIND_FETCH = 2'd0;

    localparam logic [1:0] ST_SERVED = 2'd0;
    localparam logic [1:0] ST_DEVICE = 2'd1;
    localparam logic [1:0] ST_OOB    = 2'd2;
    localparam logic [1:0] ST_ROM_RO = 2'd3;

    localparam logic [1:0] HIT_NONE = 2'd0;
    localparam logic [1:0] HIT_ROM  = 2'd1;
    localparam logic [1:0] HIT_SRAM = 2'd2;
    localparam logic [1:0] HIT_MAIN = 2'd3;

    typedef struct packed {
        logic [31:0] rom_base;
        logic [31:0] sram_base;
        logic [31:0] main_base;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       region;
        logic [1:0]       status;
        logic             is_write;
        logic [1:0]       rot;
        logic [ROW_W-1:0] row;
        logic [31:0]      write_word;
        logic [3:0]       byte_enable;
    } cmd_t;

endpackage

### sv/physical_address_decoder_top.sv
// A pushed word passes the command queue, the memory stage and the result register.
// Throughput: one access per cycle while results are popped; the banked RAM read
// of the back end is the single registered step between queue and result register.
// Reset clears the queues and sets the base registers to their reset values;
// SRAM and main memory contents are undefined until written, the boot ROM reads as zero.
module physical_address_decoder_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pad_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         push,
    output logic                         full,
    input  logic [1:0]                   kind,
    input  logic [31:0]                  address,
    input  logic [31:0]                  write_word,
    input  logic [3:0]                   byte_enable,
    output logic                         empty,
    input  logic                         pop,
    output logic [31:0]                  read_word,
    output logic [1:0]                   status,
    output logic [1:0]                   region_hit
);

    pad_pkg::cfg_t cfg;
    pad_pkg::cmd_t cmd_in;
    pad_pkg::cmd_t cmd_head;
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;

    pad_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pad_front u_front (
        .push        (push),
        .full        (full),
        .kind        (kind),
        .address     (address),
        .write_word  (write_word),
        .byte_enable (byte_enable),
        .cfg         (cfg),
        .q_full      (q_full),
        .q_push      (q_push),
        .cmd         (cmd_in)
    );

    pad_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .full    (q_full),
        .cmd_in  (cmd_in),
        .pop     (q_pop),
        .empty   (q_empty),
        .cmd_out (cmd_head)
    );

    pad_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .head       (cmd_head),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .read_word  (read_word),
        .status     (status),
        .region_hit (region_hit)
    );

endmodule

### sv/pad_ram.sv
// Generic single-port RAM with registered read data.
module pad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/pad_regs.sv
// APB register file holding the three region base addresses.
module pad_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pad_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output pad_pkg::cfg_t                cfg
);

    pad_pkg::cfg_t cfg_reg;
    pad_pkg::cfg_t cfg_next;
    logic [1:0]    index;
    logic          wr_en;

    assign index  = paddr[3:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                pad_pkg::REG_ROM_BASE:  cfg_next.rom_base  = pwdata;
                pad_pkg::REG_SRAM_BASE: cfg_next.sram_base = pwdata;
                pad_pkg::REG_MAIN_BASE: cfg_next.main_base = pwdata;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rom_base  <= pad_pkg::ROM_BASE_RST;
            cfg_reg.sram_base <= pad_pkg::SRAM_BASE_RST;
            cfg_reg.main_base <= pad_pkg::MAIN_BASE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (index)
            pad_pkg::REG_ROM_BASE:  prdata = cfg_reg.rom_base;
            pad_pkg::REG_SRAM_BASE: prdata = cfg_reg.sram_base;
            pad_pkg::REG_MAIN_BASE: prdata = cfg_reg.main_base;
            default:                prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### sv/pad_front.sv
// Front end: decodes an access against the three regions and builds a command.
module pad_front (
    input  logic          push,
    output logic          full,
    input  logic [1:0]    kind,
    input  logic [31:0]   address,
    input  logic [31:0]   write_word,
    input  logic [3:0]    byte_enable,
    input  pad_pkg::cfg_t cfg,
    input  logic          q_full,
    output logic          q_push,
    output pad_pkg::cmd_t cmd
);

    localparam int RW = pad_pkg::ROW_W;

    logic [32:0] d_rom;
    logic [32:0] d_sram;
    logic [32:0] d_main;
    logic        in_rom;
    logic        in_sram;
    logic        in_main;
    logic [31:0] off;

    // The top bit of each difference is the borrow: set when the address lies below the base.
    assign d_rom  = {1'b0, address} - {1'b0, cfg.rom_base};
    assign d_sram = {1'b0, address} - {1'b0, cfg.sram_base};
    assign d_main = {1'b0, address} - {1'b0, cfg.main_base};

    assign in_rom  = !d_rom[32]  && (d_rom[31:0]  <= pad_pkg::ROM_LIM);
    assign in_sram = !d_sram[32] && (d_sram[31:0] <= pad_pkg::SRAM_LIM);
    assign in_main = !d_main[32] && (d_main[31:0] <= pad_pkg::MAIN_LIM);

    always_comb
    begin
        cmd.is_write    = kind[1];
        cmd.write_word  = write_word;
        cmd.byte_enable = byte_enable;
        if (in_rom)
        begin
            cmd.region = pad_pkg::HIT_ROM;
            off        = d_rom[31:0];
        end
        else if (in_sram)
        begin
            cmd.region = pad_pkg::HIT_SRAM;
            off        = d_sram[31:0];
        end
        else if (in_main)
        begin
            cmd.region = pad_pkg::HIT_MAIN;
            off        = d_main[31:0];
        end
        else
        begin
            cmd.region = pad_pkg::HIT_NONE;
            off        = 32'd0;
        end

        if (cmd.region == pad_pkg::HIT_NONE)
        begin
            cmd.status = (kind == pad_pkg::KIND_FETCH) ? pad_pkg::ST_OOB : pad_pkg::ST_DEVICE;
        end
        else if (kind[1] && (cmd.region == pad_pkg::HIT_ROM))
        begin
            cmd.status = pad_pkg::ST_ROM_RO;
        end
        else
        begin
            cmd.status = pad_pkg::ST_SERVED;
        end

        cmd.rot = off[1:0];
        cmd.row = off[RW+1:2];
    end

    assign full   = q_full;
    assign q_push = push && !q_full;

endmodule

### sv/pad_cmdq.sv
// Short command queue between the decode front end and the memory back end.
module pad_cmdq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  pad_pkg::cmd_t cmd_in,
    input  logic          pop,
    output logic          empty,
    output pad_pkg::cmd_t cmd_out
);

    localparam int PW = pad_pkg::CMDQ_PW;
    localparam int CW = pad_pkg::CMDQ_CW;
    localparam logic [PW-1:0] LAST = PW'(pad_pkg::CMDQ_DEPTH - 1);

    pad_pkg::cmd_t entry_reg [pad_pkg::CMDQ_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full    = (count_reg == CW'(pad_pkg::CMDQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign cmd_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(pad_pkg::CMDQ_DEPTH))
        else $error("command queue count exceeds its depth");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("command queue popped while empty");
`endif

endmodule

### sv/pad_back.sv
// Back end: runs commands against the banked SRAM and main memory and holds the result word.
module pad_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  pad_pkg::cmd_t head,
    output logic          q_pop,
    output logic          empty,
    input  logic          pop,
    output logic [31:0]   read_word,
    output logic [1:0]    status,
    output logic [1:0]    region_hit
);

    localparam int RW = pad_pkg::ROW_W;

    typedef struct packed {
        logic [1:0] region;
        logic [1:0] status;
        logic       rd;
        logic [1:0] rot;
    } stage_t;

    stage_t      s1_reg;
    stage_t      s1_next;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] read_word_reg;
    logic [31:0] read_word_next;
    logic [1:0]  status_reg;
    logic [1:0]  region_reg;

    logic        issue;
    logic        advance;
    logic        served;
    logic [3:0]  sram_en;
    logic [3:0]  main_en;
    logic [7:0]  sram_q [4];
    logic [7:0]  main_q [4];

    assign advance = s1_valid_reg && (!out_valid_reg || pop);
    assign issue   = !q_empty && (!s1_valid_reg || advance);
    assign q_pop   = issue;
    assign served  = (head.status == pad_pkg::ST_SERVED);

    // Byte lane i of an unaligned word sits in bank (rot + i) mod 4; banks below rot
    // take the next row.
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [1:0]    lane;
        logic          carry;
        logic [RW-1:0] row_b;
        logic          lane_on;
        logic [7:0]    wdata_b;

        assign lane    = 2'(b) - head.rot;
        assign carry   = (2'(b) < head.rot);
        assign row_b   = head.row + RW'(carry);
        assign lane_on = !head.is_write || head.byte_enable[lane];
        assign wdata_b = head.write_word[8*lane +: 8];

        assign sram_en[b] = issue && served && lane_on && (head.region == pad_pkg::HIT_SRAM);
        assign main_en[b] = issue && served && lane_on && (head.region == pad_pkg::HIT_MAIN);

        pad_ram #(
            .WIDTH (8),
            .DEPTH (pad_pkg::SRAM_ROWS)
        ) u_sram (
            .clk   (clk),
            .en    (sram_en[b]),
            .we    (head.is_write),
            .addr  (row_b[pad_pkg::SRAM_ROW_W-1:0]),
            .wdata (wdata_b),
            .rdata (sram_q[b])
        );

        pad_ram #(
            .WIDTH (8),
            .DEPTH (pad_pkg::MAIN_ROWS)
        ) u_main (
            .clk   (clk),
            .en    (main_en[b]),
            .we    (head.is_write),
            .addr  (row_b[pad_pkg::MAIN_ROW_W-1:0]),
            .wdata (wdata_b),
            .rdata (main_q[b])
        );
    end

    always_comb
    begin
        s1_next.region = head.region;
        s1_next.status = head.status;
        s1_next.rot    = head.rot;
        // The ROM has no memory in this block, so it reads back as zero here.
        s1_next.rd     = !head.is_write && served &&
                         ((head.region == pad_pkg::HIT_SRAM) ||
                          (head.region == pad_pkg::HIT_MAIN));

        if (issue)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_comb
    begin
        logic [1:0] sel;
        logic [7:0] byte_v;
        for (int i = 0; i < 4; i++)
        begin
            sel    = s1_reg.rot + 2'(i);
            byte_v = (s1_reg.region == pad_pkg::HIT_SRAM) ? sram_q[sel] : main_q[sel];
            read_word_next[8*i +: 8] = s1_reg.rd ? byte_v : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_reg <= s1_next;
        end
        if (advance)
        begin
            read_word_reg <= read_word_next;
            status_reg    <= s1_reg.status;
            region_reg    <= s1_reg.region;
        end
    end

    assign empty      = !out_valid_reg;
    assign read_word  = read_word_reg;
    assign status     = status_reg;
    assign region_hit = region_reg;

`ifndef SYNTH
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("stalled memory stage lost or changed its word");
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result word not held after leaving the memory stage");
    a_no_stray_access: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && !served) |-> ((sram_en == 4'd0) && (main_en == 4'd0)))
        else $error("memory accessed for a word that memory does not serve");
`endif

endmodule

### tb/physical_address_decoder_top_test.sv
// Self-checking testbench for the physical address decoder: directed and random bus accesses.
module physical_address_decoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_LOAD      = 2'd1;
    localparam logic [1:0] KIND_STORE     = 2'd2;
    localparam logic [1:0] KIND_STORE_ALT = 2'd3;

    localparam int IDLE_LIMIT   = 4000;
    localparam int REPORT_MAX   = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 200;

    typedef struct packed {
        logic [31:0] read_word;
        logic [1:0]  status;
        logic [1:0]  region;
    } reply_t;

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [pad_pkg::PADDR_W-1:0]  paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         push;
    logic                         full;
    logic [1:0]                   kind;
    logic [31:0]                  address;
    logic [31:0]                  write_word;
    logic [3:0]                   byte_enable;
    logic                         empty;
    logic                         pop;
    logic [31:0]                  read_word;
    logic [1:0]                   status;
    logic [1:0]                   region_hit;

    // Predictor state: base registers and the byte images of both RAM regions.
    logic [31:0] cfg_rom_base;
    logic [31:0] cfg_sram_base;
    logic [31:0] cfg_main_base;
    logic [7:0]  sram_img [pad_pkg::SRAM_SIZE];
    bit          sram_known [pad_pkg::SRAM_SIZE];
    logic [7:0]  main_img [pad_pkg::MAIN_SIZE];
    bit          main_known [pad_pkg::MAIN_SIZE];

    reply_t awaited_replies[$];
    int     errors;
    int     reported;
    int     burst_left;

    physical_address_decoder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .address     (address),
        .write_word  (write_word),
        .byte_enable (byte_enable),
        .empty       (empty),
        .pop         (pop),
        .read_word   (read_word),
        .status      (status),
        .region_hit  (region_hit)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic bit covers(logic [31:0] base, int size, logic [31:0] a);
        return (a >= base) && ((a - base) <= 32'(size - pad_pkg::ACCESS_BYTES));
    endfunction

    function automatic void locate(input logic [31:0] a, output logic [1:0] region,
                                   output logic [31:0] off);
        region = pad_pkg::HIT_NONE;
        off    = '0;
        if (covers(cfg_rom_base, pad_pkg::ROM_SIZE, a))
        begin
            region = pad_pkg::HIT_ROM;
            off    = a - cfg_rom_base;
        end
        else if (covers(cfg_sram_base, pad_pkg::SRAM_SIZE, a))
        begin
            region = pad_pkg::HIT_SRAM;
            off    = a - cfg_sram_base;
        end
        else if (covers(cfg_main_base, pad_pkg::MAIN_SIZE, a))
        begin
            region = pad_pkg::HIT_MAIN;
            off    = a - cfg_main_base;
        end
    endfunction

    function automatic bit touches_unwritten(logic [1:0] k, logic [31:0] a);
        logic [1:0]  region;
        logic [31:0] off;
        bit          gap;
        locate(a, region, off);
        gap = 1'b0;
        if (!k[1])
        begin
            for (int i = 0; i < pad_pkg::ACCESS_BYTES; i++)
            begin
                if (region == pad_pkg::HIT_SRAM && !sram_known[off + i])
                    gap = 1'b1;
                if (region == pad_pkg::HIT_MAIN && !main_known[off + i])
                    gap = 1'b1;
            end
        end
        return gap;
    endfunction

    // Works out the reply to one access and applies its store to the byte images.
    function automatic reply_t decode_access(logic [1:0] k, logic [31:0] a,
                                             logic [31:0] wd, logic [3:0] be);
        reply_t      r;
        logic [1:0]  region;
        logic [31:0] off;
        locate(a, region, off);
        r.read_word = '0;
        r.region    = region;
        if (region == pad_pkg::HIT_NONE)
            r.status = (k == pad_pkg::KIND_FETCH) ? pad_pkg::ST_OOB : pad_pkg::ST_DEVICE;
        else if (k[1])
        begin
            if (region == pad_pkg::HIT_ROM)
                r.status = pad_pkg::ST_ROM_RO;
            else
            begin
                for (int i = 0; i < pad_pkg::ACCESS_BYTES; i++)
                begin
                    if (be[i] && region == pad_pkg::HIT_SRAM)
                    begin
                        sram_img[off + i]   = wd[8*i +: 8];
                        sram_known[off + i] = 1'b1;
                    end
                    if (be[i] && region == pad_pkg::HIT_MAIN)
                    begin
                        main_img[off + i]   = wd[8*i +: 8];
                        main_known[off + i] = 1'b1;
                    end
                end
                r.status = pad_pkg::ST_SERVED;
            end
        end
        else
        begin
            for (int i = 0; i < pad_pkg::ACCESS_BYTES; i++)
            begin
                if (region == pad_pkg::HIT_SRAM)
                    r.read_word[8*i +: 8] = sram_img[off + i];
                else if (region == pad_pkg::HIT_MAIN)
                    r.read_word[8*i +: 8] = main_img[off + i];
            end
            r.status = pad_pkg::ST_SERVED;
        end
        return r;
    endfunction

    function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        errors++;
        if (reported < REPORT_MAX)
        begin
            reported++;
            $display("mismatch in %s: expected %h, got %h", what, want, got);
        end
    endfunction

    // Sends one word and holds push high afterwards unless the burst ends here with an idle gap.
    task automatic send_word(input logic [1:0] k, input logic [31:0] a,
                             input logic [31:0] wd, input logic [3:0] be);
        int gap;
        @(negedge clk);
        push        <= 1'b1;
        kind        <= k;
        address     <= a;
        write_word  <= wd;
        byte_enable <= be;
        do @(posedge clk); while (full);
        awaited_replies.push_back(decode_access(k, a, wd, be));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // A read of never-written RAM bytes is preceded by a full-lane store to them.
    task automatic access(input logic [1:0] k, input logic [31:0] a,
                          input logic [31:0] wd, input logic [3:0] be);
        if (touches_unwritten(k, a))
            send_word(KIND_STORE, a, $urandom, 4'hF);
        send_word(k, a, wd, be);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        push <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_base(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= pad_pkg::PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            pad_pkg::REG_ROM_BASE:  cfg_rom_base  = value;
            pad_pkg::REG_SRAM_BASE: cfg_sram_base = value;
            pad_pkg::REG_MAIN_BASE: cfg_main_base = value;
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        psel    <= 1'b1;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== value)
            note_mismatch("base register read-back", value, prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_bases(input logic [31:0] rom, input logic [31:0] sram,
                             input logic [31:0] main);
        wait_idle();
        program_base(pad_pkg::REG_ROM_BASE, rom);
        program_base(pad_pkg::REG_SRAM_BASE, sram);
        program_base(pad_pkg::REG_MAIN_BASE, main);
    endtask

    function automatic logic [1:0] pick_kind();
        int r;
        r = $urandom_range(0, 15);
        if (r < 4)
            return pad_pkg::KIND_FETCH;
        if (r < 9)
            return KIND_LOAD;
        if (r < 15)
            return KIND_STORE;
        return KIND_STORE_ALT;
    endfunction

    // Most addresses land near a region start, near its end or in a small window.
    function automatic logic [31:0] pick_address();
        int          sel;
        int          size;
        int          off;
        logic [31:0] base;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return $urandom;
        case (sel % 3)
            0:       begin base = cfg_rom_base;  size = pad_pkg::ROM_SIZE;  end
            1:       begin base = cfg_sram_base; size = pad_pkg::SRAM_SIZE; end
            default: begin base = cfg_main_base; size = pad_pkg::MAIN_SIZE; end
        endcase
        case ($urandom_range(0, 3))
            0:       off = int'($urandom_range(0, 15)) - 8;
            1:       off = size - 8 + int'($urandom_range(0, 11));
            2:       off = int'($urandom_range(0, 255));
            default: off = int'($urandom_range(0, size - 1));
        endcase
        return base + 32'(off);
    endfunction

    task automatic test_read_paths();
        access(pad_pkg::KIND_FETCH, pad_pkg::ROM_BASE_RST, 32'h0, 4'h0);
        access(KIND_LOAD, pad_pkg::ROM_BASE_RST + 32'(pad_pkg::ROM_SIZE - 4),
               32'hFFFF_FFFF, 4'hF);
        access(KIND_LOAD, pad_pkg::ROM_BASE_RST + 32'(pad_pkg::ROM_SIZE - 3), 32'h0, 4'h0);
        access(pad_pkg::KIND_FETCH, pad_pkg::ROM_BASE_RST + 32'(pad_pkg::ROM_SIZE - 3),
               32'h0, 4'h0);
        access(KIND_LOAD, 32'hFFFF_FFFF, 32'h0, 4'h0);
        access(KIND_STORE, 32'h0, 32'hFFFF_FFFF, 4'hF);
    endtask

    task automatic test_store_lanes();
        access(KIND_STORE, pad_pkg::SRAM_BASE_RST, 32'hFFFF_FFFF, 4'hF);
        access(KIND_STORE_ALT, pad_pkg::SRAM_BASE_RST + 32'd1, 32'h0, 4'b0101);
        access(KIND_STORE, pad_pkg::SRAM_BASE_RST, 32'h0, 4'h0);
        access(KIND_LOAD, pad_pkg::SRAM_BASE_RST, 32'h0, 4'h0);
        access(KIND_STORE, pad_pkg::SRAM_BASE_RST + 32'(pad_pkg::SRAM_SIZE - 4), 32'h0, 4'hF);
        access(pad_pkg::KIND_FETCH, pad_pkg::SRAM_BASE_RST + 32'(pad_pkg::SRAM_SIZE - 4),
               32'h0, 4'h0);
        access(KIND_STORE, pad_pkg::MAIN_BASE_RST, 32'hA5C3_3C5A, 4'hF);
        access(KIND_STORE, pad_pkg::MAIN_BASE_RST + 32'd4, 32'h1234_5678, 4'hF);
        access(KIND_LOAD, pad_pkg::MAIN_BASE_RST + 32'd1, 32'h0, 4'h0);
        access(pad_pkg::KIND_FETCH, pad_pkg::MAIN_BASE_RST + 32'd3, 32'h0, 4'h0);
    endtask

    task automatic test_rom_refusal();
        access(KIND_STORE, pad_pkg::ROM_BASE_RST, 32'hDEAD_BEEF, 4'hF);
        access(KIND_STORE_ALT, pad_pkg::ROM_BASE_RST + 32'(pad_pkg::ROM_SIZE - 4),
               32'h0, 4'h0);
    endtask

    // All three regions start at one base, so priority decides each word.
    task automatic test_overlap();
        set_bases(32'h4000_0000, 32'h4000_0000, 32'h4000_0000);
        access(pad_pkg::KIND_FETCH, 32'h4000_0000 + 32'(pad_pkg::ROM_SIZE - 4), 32'h0, 4'h0);
        access(KIND_LOAD, 32'h4000_0000 + 32'(pad_pkg::ROM_SIZE - 3), 32'h0, 4'h0);
        access(KIND_STORE, 32'h4000_0000 + 32'(pad_pkg::SRAM_SIZE - 3), $urandom, 4'b1001);
    endtask

    task automatic test_top_of_space();
        set_bases(32'hFFFF_F000, 32'h0, 32'hFFFF_FFFF);
        access(KIND_STORE, 32'hFFFF_FFFF, $urandom, 4'hF);
        access(KIND_LOAD, 32'hFFFF_FFFF, 32'h0, 4'h0);
        access(pad_pkg::KIND_FETCH, 32'hFFFF_FFFC, 32'h0, 4'h0);
        access(KIND_LOAD, 32'hFFFF_FFFD, 32'h0, 4'h0);
    endtask

    task automatic test_random_traffic();
        logic [31:0] b;
        for (int phase = 0; phase < 8; phase++)
        begin
            b = $urandom;
            case (phase)
                0: set_bases(pad_pkg::ROM_BASE_RST, pad_pkg::SRAM_BASE_RST,
                             pad_pkg::MAIN_BASE_RST);
                1: set_bases(b, b + 32'(pad_pkg::ROM_SIZE - 2),
                             b + 32'(pad_pkg::ROM_SIZE + pad_pkg::SRAM_SIZE - 4));
                2: set_bases(32'h0, 32'h0, 32'h0);
                3: set_bases(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                4: set_bases(32'hFFFF_F000, 32'hFFFF_E000, 32'hFFFF_0000);
                7: set_bases(b + 32'd256, b, b);
                default: set_bases($urandom, $urandom, $urandom);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                access(pick_kind(), pick_address(), $urandom, 4'($urandom_range(0, 15)));
        end
    endtask

    // The receiver cycles through steady, light, heavy and periodic stalls.
    initial
    begin : reply_pacer
        int cyc;
        bit take;
        cyc = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            case ((cyc / 97) % 4)
                0:       take = 1'b1;
                1:       take = ($urandom_range(0, 3) != 0);
                2:       take = ($urandom_range(0, 3) == 0);
                default: take = ((cyc % 7) < 2);
            endcase
            pop <= take;
            cyc++;
        end
    end

    initial
    begin : reply_checker
        reply_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (awaited_replies.size() == 0)
                    note_mismatch("word with nothing awaited", 32'h0, read_word);
                else
                begin
                    want = awaited_replies.pop_front();
                    if (read_word !== want.read_word)
                        note_mismatch("read_word", want.read_word, read_word);
                    if (status !== want.status)
                        note_mismatch("status", 32'(want.status), 32'(status));
                    if (region_hit !== want.region)
                        note_mismatch("region_hit", 32'(want.region), 32'(region_hit));
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("physical_address_decoder_top_test failed");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        push          = 1'b0;
        kind          = pad_pkg::KIND_FETCH;
        address       = '0;
        write_word    = '0;
        byte_enable   = '0;
        errors        = 0;
        reported      = 0;
        burst_left    = 0;
        cfg_rom_base  = pad_pkg::ROM_BASE_RST;
        cfg_sram_base = pad_pkg::SRAM_BASE_RST;
        cfg_main_base = pad_pkg::MAIN_BASE_RST;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_read_paths();
        test_store_lanes();
        test_rom_refusal();
        test_overlap();
        test_top_of_space();
        test_random_traffic();
        wait_idle();

        if (errors == 0 && awaited_replies.size() == 0)
            $display("physical_address_decoder_top_test passed");
        else
            $display("physical_address_decoder_top_test failed");
        $finish;
    end

endmodule
